// ===== sv/framebuffer_pixel_converter_macros.svh =====
// Assertion macros for the framebuffer pixel converter.
// No dependencies; included by the top level. Define ASSERT_OFF to drop them.
`ifndef FRAMEBUFFER_PIXEL_CONVERTER_MACROS_SVH
`define FRAMEBUFFER_PIXEL_CONVERTER_MACROS_SVH

`ifndef ASSERT_OFF

// Same-cycle implication under reset
`define FBPC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fbpc assertion failed");

// Next-cycle implication under reset
`define FBPC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fbpc assertion failed");

`else

`define FBPC_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define FBPC_ASSERT_NXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== sv/fbpc_pkg.sv =====
// Shared types, codes and helper functions for the framebuffer pixel converter.
// No dependencies; used by the configuration registers and the top level.
package fbpc_pkg;

    localparam int WORD_W     = 32;
    localparam int IDX_W      = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 5;
    localparam int SUM_W      = 15;

    // floor(s / 100) == (s * 41944) >> 22 for every s below 25600
    localparam logic [15:0] GRAY_RECIP = 16'd41944;
    localparam int          GRAY_SHIFT = 22;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_RED_SHIFT,
        REG_RED_WIDTH,
        REG_GREEN_SHIFT,
        REG_GREEN_WIDTH,
        REG_BLUE_SHIFT,
        REG_BLUE_WIDTH,
        REG_INVERT_MONO
    } cfg_reg_t;

    typedef enum logic {
        OP_CONVERT,
        OP_PAL_WRITE
    } opcode_t;

    typedef enum logic [1:0] {
        CH_RED,
        CH_GREEN,
        CH_BLUE
    } channel_t;

    typedef struct packed {
        logic [4:0] red_shift;
        logic [3:0] red_width;
        logic [4:0] green_shift;
        logic [3:0] green_width;
        logic [4:0] blue_shift;
        logic [3:0] blue_width;
        logic       invert_mono;
    } fbpc_cfg_t;

    // Take the channel field at shift/width; widths above eight saturate
    function automatic logic [IDX_W-1:0] field_index(
        input logic [WORD_W-1:0] word,
        input logic [4:0]        shift,
        input logic [3:0]        width
    );
        logic [3:0]        w;
        logic [IDX_W:0]    mask;
        logic [WORD_W-1:0] shifted;
        w       = (width > 4'd8) ? 4'd8 : width;
        mask    = ((IDX_W+1)'(1) << w) - (IDX_W+1)'(1);
        shifted = word >> shift;
        return shifted[IDX_W-1:0] & mask[IDX_W-1:0];
    endfunction

    // Mirror the bit order of a byte
    function automatic logic [7:0] reverse_byte(input logic [7:0] b);
        logic [7:0] r;
        for (int i = 0; i < 8; i++)
        begin
            r[i] = b[7-i];
        end
        return r;
    endfunction

    // Weighted luminance sum 30r + 59g + 11b, at most 25500
    function automatic logic [SUM_W-1:0] luma_sum(
        input logic [7:0] r,
        input logic [7:0] g,
        input logic [7:0] b
    );
        return SUM_W'(r) * SUM_W'(30) + SUM_W'(g) * SUM_W'(59) + SUM_W'(b) * SUM_W'(11);
    endfunction

endpackage

// ===== sv/fbpc_palette_ram.sv =====
// One channel palette: single write port, single registered read port.
// Depends on nothing; instantiated three times by the top level.
module fbpc_palette_ram #(
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [7:0]               wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [7:0]               rdata
);

    logic [7:0] mem [DEPTH];
    logic [7:0] rdata_reg;

    // Store an entry
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read an entry; hold the word when not enabled
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/fbpc_cfg_regs.sv =====
// Configuration register file of the framebuffer pixel converter.
// Depends on fbpc_pkg for the register codes and the configuration struct.
module fbpc_cfg_regs
    import fbpc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  wr_en,
    input  logic [CFG_IDX_W-1:0]  wr_index,
    input  logic [CFG_DATA_W-1:0] wr_data,
    output fbpc_cfg_t             cfg
);

    fbpc_cfg_t cfg_reg;
    fbpc_cfg_t cfg_next;

    // Decode the register index and update one field
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (cfg_reg_t'(wr_index))
                REG_RED_SHIFT:   cfg_next.red_shift   = wr_data[4:0];
                REG_RED_WIDTH:   cfg_next.red_width   = wr_data[3:0];
                REG_GREEN_SHIFT: cfg_next.green_shift = wr_data[4:0];
                REG_GREEN_WIDTH: cfg_next.green_width = wr_data[3:0];
                REG_BLUE_SHIFT:  cfg_next.blue_shift  = wr_data[4:0];
                REG_BLUE_WIDTH:  cfg_next.blue_width  = wr_data[3:0];
                REG_INVERT_MONO: cfg_next.invert_mono = wr_data[0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    // Hold the registers; reset to RGB888 layout, mono not inverted
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.red_shift   <= 5'd16;
            cfg_reg.red_width   <= 4'd8;
            cfg_reg.green_shift <= 5'd8;
            cfg_reg.green_width <= 4'd8;
            cfg_reg.blue_shift  <= 5'd0;
            cfg_reg.blue_width  <= 4'd8;
            cfg_reg.invert_mono <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== sv/framebuffer_pixel_converter.sv =====
// Framebuffer pixel converter: palette lookup, gray and mono output per pixel word.
// The palette read is registered at the accepting edge, then the luma sum in stage 2, then
// gray scaling into the output register. Throughput: one word per cycle while the output
// is not stalled, set by the single read port of each palette RAM. Stages stall
// independently, so bubbles are filled under a stalled output. Reset clears valid bits and
// restores configuration defaults; palette contents are not cleared and must be written.
`include "framebuffer_pixel_converter_macros.svh"

module framebuffer_pixel_converter
    import fbpc_pkg::*;
#(
    parameter int PALETTE_DEPTH = 256,
    parameter int PIXEL_BITS    = 32
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic                  opcode,
    input  logic [PIXEL_BITS-1:0] pixel_word,
    input  logic [1:0]            palette_channel,
    input  logic [7:0]            palette_index,
    input  logic [15:0]           palette_value,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [7:0]            red_out,
    output logic [7:0]            green_out,
    output logic [7:0]            blue_out,
    output logic [7:0]            gray_out,
    output logic [7:0]            mono_out,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int             ADDR_W    = $clog2(PALETTE_DEPTH);
    localparam logic [IDX_W:0] DEPTH_LIM = (IDX_W+1)'(PALETTE_DEPTH);

    fbpc_cfg_t cfg;

    // Input side
    logic              accept;
    logic              is_write;
    logic              wr_ok;
    logic [WORD_W-1:0] word;
    logic [IDX_W-1:0]  idx_red;
    logic [IDX_W-1:0]  idx_green;
    logic [IDX_W-1:0]  idx_blue;
    logic [2:0]        oor_next;
    logic [7:0]        mono_next;
    logic              we_red;
    logic              we_green;
    logic              we_blue;

    // Stage 1: palette read data
    logic              v1_reg;
    logic              v1_next;
    opcode_t           op1_reg;
    logic [2:0]        oor1_reg;
    logic [7:0]        mono1_reg;
    logic [7:0]        rd_red;
    logic [7:0]        rd_green;
    logic [7:0]        rd_blue;
    logic [7:0]        red_s1;
    logic [7:0]        green_s1;
    logic [7:0]        blue_s1;
    logic [7:0]        mono_s1;

    // Stage 2: luma sum
    logic              v2_reg;
    logic              v2_next;
    logic [7:0]        red2_reg;
    logic [7:0]        green2_reg;
    logic [7:0]        blue2_reg;
    logic [7:0]        mono2_reg;
    logic [SUM_W-1:0]  sum2_reg;
    logic [SUM_W+15:0] gray_prod;

    // Output register
    logic              out_valid_reg;
    logic              out_valid_next;
    logic [7:0]        red_out_reg;
    logic [7:0]        green_out_reg;
    logic [7:0]        blue_out_reg;
    logic [7:0]        gray_out_reg;
    logic [7:0]        mono_out_reg;

    logic              load_out;
    logic              load2;

    // Configuration registers; writes are always taken
    assign cfg_ready = 1'b1;

    fbpc_cfg_regs u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid & cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    // Per-stage advance: a stage loads when empty or when it empties this cycle
    assign load_out = v2_reg & (~out_valid_reg | out_ready);
    assign load2    = v1_reg & (~v2_reg | load_out);
    assign in_ready = ~v1_reg | load2;
    assign accept   = in_valid & in_ready;

    // Extract channel indices and build the mono byte
    assign word      = WORD_W'(pixel_word);
    assign idx_red   = field_index(word, cfg.red_shift, cfg.red_width);
    assign idx_green = field_index(word, cfg.green_shift, cfg.green_width);
    assign idx_blue  = field_index(word, cfg.blue_shift, cfg.blue_width);
    assign oor_next  = {({1'b0, idx_blue}  >= DEPTH_LIM),
                        ({1'b0, idx_green} >= DEPTH_LIM),
                        ({1'b0, idx_red}   >= DEPTH_LIM)};
    assign mono_next = reverse_byte(pixel_word[7:0]) ^ {8{cfg.invert_mono}};

    // Palette writes: drop out-of-range indices and the unused channel code
    assign is_write = (opcode_t'(opcode) == OP_PAL_WRITE);
    assign wr_ok    = accept & is_write & ({1'b0, palette_index} < DEPTH_LIM);
    assign we_red   = wr_ok & (channel_t'(palette_channel) == CH_RED);
    assign we_green = wr_ok & (channel_t'(palette_channel) == CH_GREEN);
    assign we_blue  = wr_ok & (channel_t'(palette_channel) == CH_BLUE);

    fbpc_palette_ram #(.DEPTH(PALETTE_DEPTH)) u_red_pal (
        .clk   (clk),
        .we    (we_red),
        .waddr (palette_index[ADDR_W-1:0]),
        .wdata (palette_value[15:8]),
        .re    (accept),
        .raddr (idx_red[ADDR_W-1:0]),
        .rdata (rd_red)
    );

    fbpc_palette_ram #(.DEPTH(PALETTE_DEPTH)) u_green_pal (
        .clk   (clk),
        .we    (we_green),
        .waddr (palette_index[ADDR_W-1:0]),
        .wdata (palette_value[15:8]),
        .re    (accept),
        .raddr (idx_green[ADDR_W-1:0]),
        .rdata (rd_green)
    );

    fbpc_palette_ram #(.DEPTH(PALETTE_DEPTH)) u_blue_pal (
        .clk   (clk),
        .we    (we_blue),
        .waddr (palette_index[ADDR_W-1:0]),
        .wdata (palette_value[15:8]),
        .re    (accept),
        .raddr (idx_blue[ADDR_W-1:0]),
        .rdata (rd_blue)
    );

    // Valid bits: fill on load, drain when the next stage takes the word
    always_comb
    begin
        v1_next        = accept   ? 1'b1 : (load2    ? 1'b0 : v1_reg);
        v2_next        = load2    ? 1'b1 : (load_out ? 1'b0 : v2_reg);
        out_valid_next = load_out ? 1'b1 : ((out_valid_reg & out_ready) ? 1'b0 :
                                            out_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            v1_reg        <= v1_next;
            v2_reg        <= v2_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Stage 1 side information, captured alongside the palette read
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op1_reg   <= opcode_t'(opcode);
            oor1_reg  <= oor_next;
            mono1_reg <= mono_next;
        end
    end

    // Zero the channels on a palette write or an index beyond the palette
    always_comb
    begin
        red_s1   = (op1_reg == OP_PAL_WRITE || oor1_reg[0]) ? 8'd0 : rd_red;
        green_s1 = (op1_reg == OP_PAL_WRITE || oor1_reg[1]) ? 8'd0 : rd_green;
        blue_s1  = (op1_reg == OP_PAL_WRITE || oor1_reg[2]) ? 8'd0 : rd_blue;
        mono_s1  = (op1_reg == OP_PAL_WRITE) ? 8'd0 : mono1_reg;
    end

    // Stage 2: register channels and the weighted sum
    always_ff @(posedge clk)
    begin
        if (load2)
        begin
            red2_reg   <= red_s1;
            green2_reg <= green_s1;
            blue2_reg  <= blue_s1;
            mono2_reg  <= mono_s1;
            sum2_reg   <= luma_sum(red_s1, green_s1, blue_s1);
        end
    end

    // Divide by 100 through the reciprocal multiply
    assign gray_prod = (SUM_W+16)'(sum2_reg) * (SUM_W+16)'(GRAY_RECIP);

    // Output register
    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            red_out_reg   <= red2_reg;
            green_out_reg <= green2_reg;
            blue_out_reg  <= blue2_reg;
            gray_out_reg  <= gray_prod[GRAY_SHIFT +: 8];
            mono_out_reg  <= mono2_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign red_out   = red_out_reg;
    assign green_out = green_out_reg;
    assign blue_out  = blue_out_reg;
    assign gray_out  = gray_out_reg;
    assign mono_out  = mono_out_reg;

    // A word waiting in stage 1 is never lost while stage 2 is blocked
    `FBPC_ASSERT_NXT(a_s1_hold, clk, rst_n, v1_reg && !load2, v1_reg)
    // With every stage full and the output stalled, no new word is taken
    `FBPC_ASSERT_IMP(a_full_stall, clk, rst_n,
                     v1_reg && v2_reg && out_valid_reg && !out_ready, !in_ready)
    // A palette write carries an all-zero result into stage 2
    `FBPC_ASSERT_NXT(a_write_zero, clk, rst_n, load2 && (op1_reg == OP_PAL_WRITE),
                     (sum2_reg == '0) && (mono2_reg == '0))

endmodule
